// ----- hw/rtl/pts_pkg.sv -----
// Package for the periodic timer scheduler: payload structs, codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_RESET   = 2'd1,
        CMD_KILL    = 2'd2,
        CMD_PROCESS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_FIRED   = 2'd1,
        KIND_SUMMARY = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic [31:0] period_ms;
        logic [47:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  fired_slot;
        logic [31:0] wait_ms;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_DECIDE,
        ST_FIRE,
        ST_SUMMARY,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic do_cmd;    // apply set/reset/kill
        logic scan_clr;  // start a scan
        logic scan_step; // examine one slot
        logic advance;   // add period to best slot due
        logic out_ack;
        logic out_fire;
        logic out_sum;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic        is_process;
        logic        scan_done;
        logic        due_now; // a best slot exists and is due
    } t_sts;

    localparam logic [47:0] MAX_DUE  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX_WAIT = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ----- hw/rtl/periodic_timer_scheduler.sv -----
// Top level of the periodic timer scheduler: controller plus datapath.
// Depends on pts_pkg, pts_ctrl, pts_datapath.
//
//   channel | signals                          | payload
//   in      | i_in_valid / o_in_ready          | i_in (t_in_item)
//   out     | o_out_valid / i_out_ready        | o_out (t_out_item)
//
// Set/reset/kill: the item is loaded in IDLE, applied together with the ack in CMD,
// then held in OUT until taken. Process: each fire decision takes a serial scan
// (one table read per cycle), then a decide, an output and an update state;
// fires repeat until no slot is due or MAX_FIRES is reached, then a summary is sent.
// Reset clears active flags and control; tables are written before use.
// A stalled output holds the controller; no new item is taken until the
// last result of the current item is transferred.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int MAX_FIRES = 63
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out
);
    t_ctl w_ctl;
    t_sts w_sts;

    pts_ctrl #(.MAX_FIRES(MAX_FIRES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    pts_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/pts_datapath.sv -----
// Datapath: slot table memories, serial earliest-due scan, output register.
// Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_datapath
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_ctl      i_ctl,
    output t_sts           o_sts,
    output t_out_item      o_out
);
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic [NUM_SLOTS-1:0] r_active;
    logic [31:0]          r_period [NUM_SLOTS];
    logic [47:0]          r_due    [NUM_SLOTS];

    t_in_item    r_item;
    logic [31:0] r_per_in;
    logic [CW-1:0] r_idx;
    logic        r_found;
    logic [IW-1:0] r_best;
    logic [47:0] r_best_due;
    logic [31:0] r_best_per;
    logic [47:0] r_rd_due;
    logic [31:0] r_rd_per;
    logic        r_rd_act;
    logic        r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    logic        w_slot_ok;
    logic [IW-1:0] w_slot;
    logic [48:0] w_sum_cmd;
    logic [48:0] w_sum_adv;
    logic [47:0] w_wait48;

    assign w_slot_ok = {28'd0, r_item.slot} < NUM_SLOTS;
    assign w_slot    = IW'(r_item.slot);
    assign w_sum_cmd = {1'b0, r_item.now_ms} + {17'd0, r_per_in};
    assign w_sum_adv = {1'b0, r_best_due} + {17'd0, r_best_per};
    assign w_wait48  = r_best_due - r_item.now_ms;

    // Input capture, period zero stored as one
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item   <= i_item;
            r_per_in <= (i_item.period_ms == 32'd0) ? 32'd1 : i_item.period_ms;
        end
    end

    // Active flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_ctl.do_cmd && w_slot_ok) begin
            if (r_item.cmd == CMD_SET) begin
                r_active[w_slot] <= 1'b1;
            end else if (r_item.cmd == CMD_KILL) begin
                r_active[w_slot] <= 1'b0;
            end
        end
    end

    // Period and due memories: single write port, one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_cmd && w_slot_ok) begin
            if (r_item.cmd == CMD_SET || r_item.cmd == CMD_RESET) begin
                r_period[w_slot] <= r_per_in;
            end
            if (r_item.cmd == CMD_SET ||
                (r_item.cmd == CMD_RESET && r_active[w_slot])) begin
                r_due[w_slot] <= w_sum_cmd[48] ? MAX_DUE : w_sum_cmd[47:0];
            end
        end else if (i_ctl.advance) begin
            r_due[r_best] <= w_sum_adv[48] ? MAX_DUE : w_sum_adv[47:0];
        end
        r_rd_due <= r_due[IW'(r_idx)];
        r_rd_per <= r_period[IW'(r_idx)];
        r_rd_act <= r_active[IW'(r_idx)];
        r_rd_idx <= IW'(r_idx);
    end

    // Serial scan: one slot read per cycle, compared in the next cycle from the registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else if (i_ctl.scan_clr) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else if (i_ctl.scan_step) begin
            r_rd_vld <= (r_idx < CW'(NUM_SLOTS));
            if (r_idx < CW'(NUM_SLOTS)) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_rd_vld && r_rd_act && (!r_found || r_rd_due < r_best_due)) begin
                r_found    <= 1'b1;
                r_best     <= r_rd_idx;
                r_best_due <= r_rd_due;
                r_best_per <= r_rd_per;
            end
        end
    end

    assign o_sts.is_process = (r_item.cmd == CMD_PROCESS);
    assign o_sts.scan_done  = (r_idx == CW'(NUM_SLOTS)) && !r_rd_vld;
    assign o_sts.due_now    = r_found && (r_best_due <= r_item.now_ms);

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_ack) begin
            o_out <= '{kind: KIND_ACK, fired_slot: 4'd0, wait_ms: 32'd0, last: 1'b1};
        end else if (i_ctl.out_fire) begin
            o_out <= '{kind: KIND_FIRED, fired_slot: 4'(r_best), wait_ms: 32'd0,
                       last: 1'b0};
        end else if (i_ctl.out_sum) begin
            o_out.kind       <= KIND_SUMMARY;
            o_out.fired_slot <= 4'd0;
            o_out.last       <= 1'b1;
            if (!r_found || r_best_due <= r_item.now_ms) begin
                o_out.wait_ms <= 32'd0;
            end else if (w_wait48[47:32] != 16'd0) begin
                o_out.wait_ms <= MAX_WAIT;
            end else begin
                o_out.wait_ms <= w_wait48[31:0];
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pts_ctrl.sv -----
// Controller FSM: sequences commands, scans, fires and output handshake.
// Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_ctrl
    import pts_pkg::*;
#(
    parameter int MAX_FIRES = 63
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl
);
    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [5:0] r_fires, n_fires;
    logic       r_ovld, n_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_fires <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fires <= n_fires;
            r_ovld  <= n_ovld;
        end
    end

    assign o_out_valid = r_ovld;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_fires    = r_fires;
        n_ovld     = r_ovld;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_CMD;
                end
            end
            ST_CMD: begin
                n_fires = '0;
                if (i_sts.is_process) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state        = ST_SCAN;
                end else begin
                    o_ctl.do_cmd  = 1'b1;
                    o_ctl.out_ack = 1'b1;
                    n_ovld        = 1'b1;
                    n_ret         = ST_IDLE;
                    n_state       = ST_OUT;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (i_sts.due_now && r_fires != 6'(MAX_FIRES)) begin
                    o_ctl.out_fire = 1'b1;
                    n_ovld         = 1'b1;
                    n_ret          = ST_FIRE;
                end else begin
                    o_ctl.out_sum = 1'b1;
                    n_ovld        = 1'b1;
                    n_ret         = ST_IDLE;
                end
                n_state = ST_OUT;
            end
            ST_FIRE: begin
                o_ctl.advance  = 1'b1;
                o_ctl.scan_clr = 1'b1;
                n_fires        = r_fires + 6'd1;
                n_state        = ST_SCAN;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_ovld  = 1'b0;
                    n_state = r_ret;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for periodic_timer_scheduler: random command and
// process traffic with bursty input and stalling output. Depends on pts_pkg.
`timescale 1ns / 1ps
module tb_top;
    import pts_pkg::*;

    localparam int N_SLOTS   = 16;
    localparam int FIRE_CAP  = 63;
    localparam int N_RANDOM  = 450;
    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam logic [47:0] DUE_MAX = 48'hFFFF_FFFF_FFFF;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    periodic_timer_scheduler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #10 i_clk = ~i_clk;

    // Shadow timer table
    logic        tmr_active [N_SLOTS];
    logic [31:0] tmr_period [N_SLOTS];
    logic [47:0] tmr_due    [N_SLOTS];

    t_in_item  pending_cmds[$];
    t_out_item expected_results[$];
    int        error_count = 0;
    bit        stim_done = 1'b0;
    longint    cycle_count = 0;
    logic [47:0] clock_ms = 48'd0;
    bit        in_accepted = 1'b0;

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? DUE_MAX : s[47:0];
    endfunction

    function automatic int earliest_timer();
        int best;
        best = -1;
        for (int i = 0; i < N_SLOTS; i++)
            if (tmr_active[i] && (best < 0 || tmr_due[i] < tmr_due[best]))
                best = i;
        return best;
    endfunction

    function automatic t_out_item mk_result(t_kind k, logic [3:0] s,
                                            logic [31:0] w, logic l);
        t_out_item r;
        r.kind = k; r.fired_slot = s; r.wait_ms = w; r.last = l;
        return r;
    endfunction

    // Apply one command to the shadow table and queue its results
    task automatic schedule_results(t_in_item it);
        logic [31:0] per;
        int b, n;
        logic [47:0] wt;
        per = (it.period_ms == 0) ? 32'd1 : it.period_ms;
        if (t_cmd'(it.cmd) != CMD_PROCESS) begin
            case (t_cmd'(it.cmd))
                CMD_SET: begin
                    tmr_active[it.slot] = 1'b1;
                    tmr_period[it.slot] = per;
                    tmr_due[it.slot] = add_sat(it.now_ms, per);
                end
                CMD_RESET: begin
                    tmr_period[it.slot] = per;
                    if (tmr_active[it.slot]) tmr_due[it.slot] = add_sat(it.now_ms, per);
                end
                default: tmr_active[it.slot] = 1'b0;
            endcase
            expected_results.push_back(mk_result(KIND_ACK, 4'd0, 32'd0, 1'b1));
        end else begin
            n = 0;
            while (n < FIRE_CAP) begin
                b = earliest_timer();
                if (b < 0 || tmr_due[b] > it.now_ms) break;
                expected_results.push_back(mk_result(KIND_FIRED, 4'(b), 32'd0, 1'b0));
                n++;
                tmr_due[b] = add_sat(tmr_due[b], tmr_period[b]);
            end
            b = earliest_timer();
            wt = 48'd0;
            if (b >= 0 && tmr_due[b] > it.now_ms) begin
                wt = tmr_due[b] - it.now_ms;
                if (wt > 48'hFFFF_FFFF) wt = 48'hFFFF_FFFF;
            end
            expected_results.push_back(mk_result(KIND_SUMMARY, 4'd0, wt[31:0], 1'b1));
        end
    endtask

    function automatic t_in_item mk_cmd(t_cmd c, logic [3:0] s, logic [31:0] p,
                                        logic [47:0] t);
        t_in_item it;
        it.cmd = c; it.slot = s; it.period_ms = p; it.now_ms = t;
        return it;
    endfunction

    // Sender: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_accepted) begin
                // hold the offered item until its transfer
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                i_in <= pending_cmds.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Accepted input transfer updates the prediction
    always @(posedge i_clk) begin
        in_accepted <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) schedule_results(i_in);
    end

    // Receiver: own stall pattern plus one long hold-off
    int stall_phase = 0;
    int hold_cycles = 0;
    bit hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            stall_phase <= stall_phase + 1;
            if (!hold_done && cycle_count > 3000) begin
                hold_cycles <= hold_cycles + 1;
                if (hold_cycles >= 2500) hold_done <= 1'b1;
                i_out_ready <= 1'b0;
            end else if (stall_phase[9]) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= (stall_phase % 7 != 3) && ($urandom_range(4, 0) != 0);
            end
        end
    end

    // Output monitor and checker
    always @(posedge i_clk) begin
        t_out_item exp_r;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d slot=%0d wait=%0d last=%0b",
                         $time, o_out.kind, o_out.fired_slot, o_out.wait_ms, o_out.last);
                error_count <= error_count + 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out !== exp_r) begin
                    $display("%0t: mismatch expected kind=%0d slot=%0d wait=%0d last=%0b",
                             $time, exp_r.kind, exp_r.fired_slot, exp_r.wait_ms, exp_r.last);
                    $display("%0t:          actual   kind=%0d slot=%0d wait=%0d last=%0b",
                             $time, o_out.kind, o_out.fired_slot, o_out.wait_ms, o_out.last);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk)
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end

    // Time never moves back here; it mostly moves in small steps
    function automatic logic [47:0] next_time();
        case ($urandom_range(9, 0))
            0:       clock_ms = clock_ms;
            1:       clock_ms = add_sat(clock_ms, $urandom());
            default: clock_ms = add_sat(clock_ms, $urandom_range(60, 0));
        endcase
        return clock_ms;
    endfunction

    initial begin
        int sel;
        logic [31:0] per;
        for (int i = 0; i < N_SLOTS; i++) begin
            tmr_active[i] = 1'b0; tmr_period[i] = '0; tmr_due[i] = '0;
        end
        // Directed: extremes, every command, ties, late timers, fire cap
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, 48'd0));
        pending_cmds.push_back(mk_cmd(CMD_KILL, 4'd15, 32'hFFFF_FFFF, 48'd0));
        pending_cmds.push_back(mk_cmd(CMD_RESET, 4'd3, 32'd0, 48'd0));
        pending_cmds.push_back(mk_cmd(CMD_SET, 4'd0, 32'd0, 48'd0));
        pending_cmds.push_back(mk_cmd(CMD_SET, 4'd15, 32'd1, 48'd0));
        pending_cmds.push_back(mk_cmd(CMD_SET, 4'd7, 32'hFFFF_FFFF, 48'd0));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd9, 32'd5, 48'd1));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, 48'd40));
        pending_cmds.push_back(mk_cmd(CMD_RESET, 4'd15, 32'd10, 48'd40));
        pending_cmds.push_back(mk_cmd(CMD_KILL, 4'd0, 32'd0, 48'd40));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, 48'd200));
        pending_cmds.push_back(mk_cmd(CMD_KILL, 4'd15, 32'd0, 48'd200));
        pending_cmds.push_back(mk_cmd(CMD_KILL, 4'd7, 32'd0, 48'd200));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, 48'd200));
        // Due saturation and wait saturation near end of time
        pending_cmds.push_back(mk_cmd(CMD_SET, 4'd5, 32'hFFFF_FFFF, DUE_MAX - 48'd5));
        pending_cmds.push_back(mk_cmd(CMD_SET, 4'd6, 32'hFFFF_FFFF, 48'h0000_0001_0000));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, 48'd300));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, DUE_MAX));
        pending_cmds.push_back(mk_cmd(CMD_KILL, 4'd5, 32'd0, DUE_MAX));
        pending_cmds.push_back(mk_cmd(CMD_KILL, 4'd6, 32'd0, DUE_MAX));
        // Time going back afterwards is taken as given; restart near zero
        pending_cmds.push_back(mk_cmd(CMD_SET, 4'd2, 32'd1, 48'd10));
        pending_cmds.push_back(mk_cmd(CMD_SET, 4'd4, 32'd1, 48'd10));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, 48'd500));
        pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'd0, 32'd0, 48'd600));
        clock_ms = 48'd600;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random traffic: arming with mostly short periods, frequent processes
        for (int k = 0; k < N_RANDOM; k++) begin
            sel = $urandom_range(99, 0);
            case ($urandom_range(7, 0))
                0:       per = $urandom();
                1:       per = 32'd0;
                default: per = $urandom_range(40, 1);
            endcase
            if (sel < 35)
                pending_cmds.push_back(mk_cmd(CMD_SET, 4'($urandom_range(15, 0)), per,
                                              next_time()));
            else if (sel < 45)
                pending_cmds.push_back(mk_cmd(CMD_RESET, 4'($urandom_range(15, 0)), per,
                                              next_time()));
            else if (sel < 55)
                pending_cmds.push_back(mk_cmd(CMD_KILL, 4'($urandom_range(15, 0)),
                                              $urandom(), next_time()));
            else if (sel < 58)
                pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'($urandom_range(15, 0)),
                                              $urandom(), {$urandom(), 16'($urandom())}));
            else
                pending_cmds.push_back(mk_cmd(CMD_PROCESS, 4'($urandom_range(15, 0)),
                                              $urandom(), next_time()));
            if (sel == 57) clock_ms = 48'd0;
        end

        wait (pending_cmds.size() == 0 && !i_in_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/pts_pkg.sv
hw/rtl/pts_datapath.sv
hw/rtl/pts_ctrl.sv
hw/rtl/periodic_timer_scheduler.sv
sim/tb_top.sv
